### hw/rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int unsigned QW    = 32;
  localparam int unsigned FRACW = 16;
  localparam int unsigned DVDW  = QW + FRACW;
  localparam int unsigned CNTW  = $clog2(DVDW);
  localparam int unsigned STW   = 3;
  localparam int unsigned DEPW  = 7;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_OPER   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [STW-1:0] ST_OK        = 3'd0;
  localparam logic [STW-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STW-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STW-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STW-1:0] ST_SATURATED = 3'd4;

  localparam logic [QW-1:0] Q_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [QW-1:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q_MIN       = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [QW-1:0] operand_value;
    logic [1:0]           op_code;
  } in_t;

  typedef struct packed {
    logic signed [QW-1:0] result_value;
    logic [STW-1:0]       status;
    logic [DEPW-1:0]      stack_depth;
  } out_t;

endpackage

### hw/rtl/rpn_stack_evaluator.sv
// A push or an unused mode goes straight to S_DONE, which loads the output register. A finish
// pops in S_FIN; an operator pops in S_POPL and S_EXEC, works in S_OP, S_MULS for multiply or
// S_DIV and S_DIVF for a nonzero divisor, and pushes in S_PUSH. A restoring divider gives one
// of 48 quotient bits per cycle; the two stack reads share the single read port of the stack
// memory. A result waits while the last one is unaccepted; the next item can be accepted in the
// cycle after the load. Reset empties the stack, drops any waiting result, keeps the memory.
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rpn_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rpn_pkg::out_t       out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QW = rpn_pkg::QW;
  localparam int unsigned DVDW = rpn_pkg::DVDW;
  localparam int unsigned CNTW = rpn_pkg::CNTW;
  localparam int unsigned STW = rpn_pkg::STW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POPL = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_OP   = 4'd3;
  localparam logic [3:0] S_MULS = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_DIVF = 4'd6;
  localparam logic [3:0] S_PUSH = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [QW-1:0] stack_mem [STACK_DEPTH];
  logic [QW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [QW-1:0] mem_wd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic [3:0]      state_q, state_d;
  logic [PW-1:0]   sp_q, sp_d;
  logic [PW-1:0]   sp_m1;
  logic [1:0]      op_q, op_d;
  logic            pop_ok_q, pop_ok_d;
  logic            under_q, under_d;
  logic [QW-1:0]   right_q, right_d;
  logic [QW-1:0]   left_q, left_d;
  logic [QW-1:0]   res_q, res_d;
  logic [STW-1:0]  st_q, st_d;
  logic [63:0]     prod_q, prod_d;
  logic [QW-1:0]   dvs_q, dvs_d;
  logic [QW-1:0]   rem_q, rem_d;
  logic [DVDW-1:0] quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  rpn_pkg::out_t   out_data_q;

  logic [QW:0]     add_sum;
  logic            add_ovf;
  logic [QW-1:0]   add_res;
  logic            mul_fit;
  logic [QW-1:0]   mul_res;
  logic [QW-1:0]   l_mag;
  logic [QW-1:0]   r_mag;
  logic [QW:0]     div_sh;
  logic [QW+1:0]   div_diff;
  logic            div_ge;
  logic            div_ovf;
  logic [QW-1:0]   div_res;

  function automatic logic [STW-1:0] pick_status(input logic under, input logic divz,
                                                 input logic sat);
    logic [STW-1:0] st;
    st = rpn_pkg::ST_OK;
    if (under) begin
      st = rpn_pkg::ST_UNDERFLOW;
    end else if (divz) begin
      st = rpn_pkg::ST_DIVZERO;
    end else if (sat) begin
      st = rpn_pkg::ST_SATURATED;
    end
    return st;
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  assign sp_m1 = PW'(sp_q - PW'(1));

  assign add_sum = (op_q == rpn_pkg::OP_SUB) ? ({left_q[QW-1], left_q} - {right_q[QW-1], right_q})
                                             : ({left_q[QW-1], left_q} + {right_q[QW-1], right_q});
  assign add_ovf = add_sum[QW] ^ add_sum[QW-1];
  assign add_res = add_ovf ? (add_sum[QW] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX) : add_sum[QW-1:0];

  assign mul_fit = (prod_q[63:47] == {17{prod_q[63]}});
  assign mul_res = mul_fit ? prod_q[47:16] : (prod_q[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX);

  assign l_mag = left_q[QW-1] ? (~left_q + 32'd1) : left_q;
  assign r_mag = right_q[QW-1] ? (~right_q + 32'd1) : right_q;

  assign div_sh   = {rem_q, quo_q[DVDW-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, dvs_q};
  assign div_ge   = !div_diff[QW+1];

  assign div_ovf = neg_q ? ((|quo_q[DVDW-1:QW]) || (quo_q[QW-1] && (|quo_q[QW-2:0])))
                         : (|quo_q[DVDW-1:QW-1]);
  assign div_res = neg_q ? (div_ovf ? rpn_pkg::Q_MIN : (~quo_q[QW-1:0] + 32'd1))
                         : (div_ovf ? rpn_pkg::Q_MAX : quo_q[QW-1:0]);

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    op_d        = op_q;
    pop_ok_d    = pop_ok_q;
    under_d     = under_q;
    right_d     = right_q;
    left_d      = left_q;
    res_d       = res_q;
    st_d        = st_q;
    prod_d      = prod_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    mem_we      = 1'b0;
    mem_wa      = sp_q[AW-1:0];
    mem_wd      = res_q;
    rd_en       = 1'b0;
    rd_addr     = sp_m1[AW-1:0];
    out_load    = 1'b0;
    in_ready_o  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.mode)
            rpn_pkg::MODE_PUSH: begin
              if (sp_q < PW'(STACK_DEPTH)) begin
                mem_we = 1'b1;
                mem_wd = in_data_i.operand_value;
                sp_d   = PW'(sp_q + PW'(1));
                res_d  = in_data_i.operand_value;
                st_d   = rpn_pkg::ST_OK;
              end else begin
                res_d = '0;
                st_d  = rpn_pkg::ST_OVERFLOW;
              end
              state_d = S_DONE;
            end
            rpn_pkg::MODE_OPER, rpn_pkg::MODE_FINISH: begin
              op_d     = in_data_i.op_code;
              pop_ok_d = (sp_q != '0);
              under_d  = (sp_q == '0);
              if (sp_q != '0) begin
                rd_en = 1'b1;
                sp_d  = sp_m1;
              end
              state_d = (in_data_i.mode == rpn_pkg::MODE_OPER) ? S_POPL : S_FIN;
            end
            default: begin
              res_d   = '0;
              st_d    = rpn_pkg::ST_OK;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_POPL: begin
        right_d  = pop_ok_q ? rd_q : rpn_pkg::Q_MINUS_ONE;
        pop_ok_d = (sp_q != '0);
        if (sp_q != '0) begin
          rd_en = 1'b1;
          sp_d  = sp_m1;
        end else begin
          under_d = 1'b1;
        end
        state_d = S_EXEC;
      end
      S_EXEC: begin
        left_d  = pop_ok_q ? rd_q : rpn_pkg::Q_MINUS_ONE;
        state_d = S_OP;
      end
      S_OP: begin
        case (op_q)
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
            res_d   = add_res;
            st_d    = pick_status(under_q, 1'b0, add_ovf);
            state_d = S_PUSH;
          end
          rpn_pkg::OP_MUL: begin
            prod_d  = 64'($signed(left_q)) * 64'($signed(right_q));
            state_d = S_MULS;
          end
          default: begin
            if (right_q == '0) begin
              res_d   = left_q[QW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
              st_d    = pick_status(under_q, 1'b1, 1'b0);
              state_d = S_PUSH;
            end else begin
              dvs_d   = r_mag;
              rem_d   = '0;
              quo_d   = {l_mag, {rpn_pkg::FRACW{1'b0}}};
              cnt_d   = CNTW'(DVDW - 1);
              neg_d   = left_q[QW-1] ^ right_q[QW-1];
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_MULS: begin
        res_d   = mul_res;
        st_d    = pick_status(under_q, 1'b0, !mul_fit);
        state_d = S_PUSH;
      end
      S_DIV: begin
        rem_d = div_ge ? div_diff[QW-1:0] : div_sh[QW-1:0];
        quo_d = {quo_q[DVDW-2:0], div_ge};
        cnt_d = CNTW'(cnt_q - CNTW'(1));
        if (cnt_q == '0) begin
          state_d = S_DIVF;
        end
      end
      S_DIVF: begin
        res_d   = div_res;
        st_d    = pick_status(under_q, 1'b0, div_ovf);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        mem_we  = 1'b1;
        mem_wd  = res_q;
        sp_d    = PW'(sp_q + PW'(1));
        state_d = S_DONE;
      end
      S_FIN: begin
        res_d   = pop_ok_q ? rd_q : rpn_pkg::Q_MINUS_ONE;
        st_d    = pop_ok_q ? rpn_pkg::ST_OK : rpn_pkg::ST_UNDERFLOW;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pop_ok_q <= pop_ok_d;
    under_q  <= under_d;
    right_q  <= right_d;
    left_q   <= left_d;
    res_q    <= res_d;
    st_q     <= st_d;
    prod_q   <= prod_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    neg_q    <= neg_d;
    if (out_load) begin
      out_data_q.result_value <= res_q;
      out_data_q.status       <= st_q;
      out_data_q.stack_depth  <= rpn_pkg::DEPW'(sp_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(STACK_DEPTH))
    else $error("Stack pointer beyond stack depth.");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (sp_q < PW'(STACK_DEPTH)))
    else $error("Stack write on a full stack.");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (sp_q != '0))
    else $error("Stack read on an empty stack.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Second item accepted while one is in progress.");

endmodule
